// ===== sv/fcgi_pkg.sv =====
// ----------------------------------------------------------------------------
// fcgi_pkg
// shared types and constants of the fastcgi record deframer
// ----------------------------------------------------------------------------
package fcgi_pkg;

    typedef enum logic [3:0] {
        EV_STDOUT     = 4'd0,
        EV_STDERR     = 4'd1,
        EV_NAME       = 4'd2,
        EV_VALUE      = 4'd3,
        EV_PAIR_LEN   = 4'd4,
        EV_END_REQ    = 4'd5,
        EV_BAD_HDR    = 4'd6,
        EV_BAD_ENDLEN = 4'd7,
        EV_UNEXP_TYPE = 4'd8,
        EV_PAIR_ERR   = 4'd9
    } event_t;

    localparam logic [7:0] TYPE_END_REQUEST   = 8'd3;
    localparam logic [7:0] TYPE_STDOUT        = 8'd6;
    localparam logic [7:0] TYPE_STDERR        = 8'd7;
    localparam logic [7:0] TYPE_VALUES_RESULT = 8'd10;
    localparam logic [7:0] TYPE_MAX           = 8'd11;
    localparam logic [7:0] FCGI_VERSION       = 8'd1;
    localparam logic [7:0] LONG_LEN_FLAG      = 8'h80;
    localparam logic [7:0] LEN_HIGH_MASK      = 8'h7f;

endpackage

// ===== sv/fastcgi_record_deframer.sv =====
// ----------------------------------------------------------------------------
// fastcgi_record_deframer
// byte-wide fastcgi record parser with stdout, stderr, name-value pair and
// end request decoding
// ----------------------------------------------------------------------------
// The block takes one stream byte per request and gives at most one event per
// byte. Each byte is handled combinationally: the parser state and the next
// event are computed from the byte and the current state, and the event is
// registered in the output stage. A new byte is accepted every cycle as long
// as the output stage is empty or is being drained in the same cycle, so the
// sustained rate is one byte per clock. Header bytes are gathered into the
// request id, content length and padding fields; the eighth header byte checks
// version and type. After a bad header every byte is dropped up to and
// including the next byte flagged as the last of a received chunk.
// Get-values-result content is decoded as name-value pairs with 1- or 4-byte
// lengths; a bad length ends pair decoding for the rest of that record.
// ----------------------------------------------------------------------------
module fastcgi_record_deframer
    import fcgi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_chunk_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_event_res,
    output logic [15:0] m_request_id,
    output logic [7:0]  m_out_byte,
    output logic [15:0] m_name_length,
    output logic [15:0] m_value_length,
    output logic [31:0] m_app_status,
    output logic [7:0]  m_protocol_status,
    output logic [7:0]  m_record_type,
    output logic        m_last_of_record
);

    // record phase
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    // pair decoder phase
    typedef enum logic [2:0] {
        PP_NAME_START  = 3'd0,
        PP_NAME_MORE   = 3'd1,
        PP_VALUE_START = 3'd2,
        PP_VALUE_MORE  = 3'd3,
        PP_BYTES       = 3'd4,
        PP_IGNORE      = 3'd6
    } pair_phase_t;

    phase_t      phase_reg, phase_next;
    pair_phase_t pair_phase_reg, pair_phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  hdr_ver_reg, hdr_ver_next;
    logic [7:0]  cur_type_reg, cur_type_next;
    logic [15:0] cur_req_reg, cur_req_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  pad_left_reg, pad_left_next;
    logic [31:0] len_acc_reg, len_acc_next;
    logic [1:0]  len_bytes_reg, len_bytes_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [16:0] pair_left_reg, pair_left_next;
    logic [2:0]  end_idx_reg, end_idx_next;
    logic [31:0] status_acc_reg, status_acc_next;

    // output stage
    logic        out_valid_reg;
    logic [3:0]  ev_reg;
    logic [15:0] req_reg;
    logic [7:0]  obyte_reg;
    logic [15:0] nlen_reg;
    logic [15:0] vlen_reg;
    logic [31:0] app_reg;
    logic [7:0]  proto_reg;
    logic [7:0]  rtype_reg;
    logic        last_reg;

    // event computed for the current byte
    logic        ev_fire;
    event_t      ev_code;
    logic [7:0]  ev_byte;
    logic [15:0] ev_nlen;
    logic [15:0] ev_vlen;
    logic [31:0] ev_app;
    logic [7:0]  ev_proto;

    logic        accept;
    logic [15:0] rem;
    logic        last_byte;
    logic [16:0] need;
    logic [31:0] len_shift;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign rem       = content_left_reg - 16'd1;
    assign last_byte = (rem == 16'd0);
    assign len_shift = {len_acc_reg[23:0], s_in_byte};

    always_comb begin
        phase_next        = phase_reg;
        pair_phase_next   = pair_phase_reg;
        hdr_idx_next      = hdr_idx_reg;
        hdr_ver_next      = hdr_ver_reg;
        cur_type_next     = cur_type_reg;
        cur_req_next      = cur_req_reg;
        content_left_next = content_left_reg;
        pad_left_next     = pad_left_reg;
        len_acc_next      = len_acc_reg;
        len_bytes_next    = len_bytes_reg;
        name_len_next     = name_len_reg;
        pair_left_next    = pair_left_reg;
        end_idx_next      = end_idx_reg;
        status_acc_next   = status_acc_reg;
        ev_fire  = 1'b0;
        ev_code  = EV_STDOUT;
        ev_byte  = 8'd0;
        ev_nlen  = 16'd0;
        ev_vlen  = 16'd0;
        ev_app   = 32'd0;
        ev_proto = 8'd0;
        need     = 17'd0;

        unique case (phase_reg)
            PH_HEADER: begin
                case (hdr_idx_reg)
                    3'd0: hdr_ver_next = s_in_byte;
                    3'd1: cur_type_next = s_in_byte;
                    3'd2: cur_req_next = {s_in_byte, cur_req_reg[7:0]};
                    3'd3: cur_req_next = {cur_req_reg[15:8], s_in_byte};
                    3'd4: content_left_next = {s_in_byte, content_left_reg[7:0]};
                    3'd5: content_left_next = {content_left_reg[15:8], s_in_byte};
                    3'd6: pad_left_next = s_in_byte;
                    default: ;
                endcase
                hdr_idx_next = hdr_idx_reg + 3'd1;
                if (hdr_idx_reg == 3'd7) begin
                    if (hdr_ver_reg != FCGI_VERSION || cur_type_reg == 8'd0
                            || cur_type_reg > TYPE_MAX) begin
                        ev_fire    = 1'b1;
                        ev_code    = EV_BAD_HDR;
                        phase_next = s_chunk_last ? PH_HEADER : PH_DISCARD;
                    end else begin
                        end_idx_next    = 3'd0;
                        status_acc_next = 32'd0;
                        len_acc_next    = 32'd0;
                        len_bytes_next  = 2'd0;
                        name_len_next   = 16'd0;
                        pair_left_next  = 17'd0;
                        pair_phase_next = PP_NAME_START;
                        if (cur_type_reg == TYPE_END_REQUEST
                                && content_left_reg != 16'd8) begin
                            ev_fire = 1'b1;
                            ev_code = EV_BAD_ENDLEN;
                            pair_phase_next = PP_IGNORE;
                        end else if (cur_type_reg != TYPE_END_REQUEST
                                && cur_type_reg != TYPE_STDOUT
                                && cur_type_reg != TYPE_STDERR
                                && cur_type_reg != TYPE_VALUES_RESULT) begin
                            ev_fire = 1'b1;
                            ev_code = EV_UNEXP_TYPE;
                            pair_phase_next = PP_IGNORE;
                        end
                        if (content_left_reg != 16'd0) begin
                            phase_next = PH_CONTENT;
                        end else begin
                            phase_next = (pad_left_reg != 8'd0) ? PH_PADDING : PH_HEADER;
                        end
                    end
                end
            end
            PH_CONTENT: begin
                content_left_next = rem;
                if (pair_phase_reg == PP_IGNORE) begin
                    // rest of record ignored
                end else if (cur_type_reg == TYPE_STDOUT || cur_type_reg == TYPE_STDERR) begin
                    ev_fire = 1'b1;
                    ev_code = (cur_type_reg == TYPE_STDOUT) ? EV_STDOUT : EV_STDERR;
                    ev_byte = s_in_byte;
                end else if (cur_type_reg == TYPE_END_REQUEST) begin
                    if (!end_idx_reg[2]) begin
                        status_acc_next = {status_acc_reg[23:0], s_in_byte};
                    end else if (end_idx_reg == 3'd4) begin
                        len_acc_next = {24'd0, s_in_byte};
                    end
                    if (end_idx_reg == 3'd7) begin
                        ev_fire  = 1'b1;
                        ev_code  = EV_END_REQ;
                        ev_app   = status_acc_reg;
                        ev_proto = len_acc_reg[7:0];
                    end
                    end_idx_next = end_idx_reg + 3'd1;
                end else if (cur_type_reg == TYPE_VALUES_RESULT) begin
                    unique case (pair_phase_reg)
                        PP_NAME_START, PP_VALUE_START: begin
                            if ((s_in_byte & LONG_LEN_FLAG) != 8'd0) begin
                                if (rem < 16'd3) begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_PAIR_ERR;
                                    pair_phase_next = PP_IGNORE;
                                end else begin
                                    len_acc_next   = {24'd0, s_in_byte & LEN_HIGH_MASK};
                                    len_bytes_next = 2'd3;
                                    pair_phase_next = (pair_phase_reg == PP_NAME_START)
                                        ? PP_NAME_MORE : PP_VALUE_MORE;
                                end
                            end else if (pair_phase_reg == PP_NAME_START) begin
                                name_len_next = {8'd0, s_in_byte};
                                if (rem == 16'd0) begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_PAIR_ERR;
                                    pair_phase_next = PP_IGNORE;
                                end else begin
                                    pair_phase_next = PP_VALUE_START;
                                end
                            end else begin
                                len_acc_next = {24'd0, s_in_byte};
                                need = {1'b0, name_len_reg} + {9'd0, s_in_byte};
                                ev_fire = 1'b1;
                                if ({1'b0, rem} < need) begin
                                    ev_code = EV_PAIR_ERR;
                                    pair_phase_next = PP_IGNORE;
                                end else begin
                                    ev_code = EV_PAIR_LEN;
                                    ev_nlen = name_len_reg;
                                    ev_vlen = {8'd0, s_in_byte};
                                    pair_left_next = need;
                                    pair_phase_next = (need != 17'd0) ? PP_BYTES : PP_NAME_START;
                                end
                            end
                        end
                        PP_NAME_MORE, PP_VALUE_MORE: begin
                            len_acc_next   = len_shift;
                            len_bytes_next = len_bytes_reg - 2'd1;
                            if (len_bytes_reg == 2'd1) begin
                                if (len_shift[31:16] != 16'd0) begin
                                    ev_fire = 1'b1;
                                    ev_code = EV_PAIR_ERR;
                                    pair_phase_next = PP_IGNORE;
                                end else if (pair_phase_reg == PP_NAME_MORE) begin
                                    name_len_next = len_shift[15:0];
                                    if (rem == 16'd0) begin
                                        ev_fire = 1'b1;
                                        ev_code = EV_PAIR_ERR;
                                        pair_phase_next = PP_IGNORE;
                                    end else begin
                                        pair_phase_next = PP_VALUE_START;
                                    end
                                end else begin
                                    need = {1'b0, name_len_reg} + {1'b0, len_shift[15:0]};
                                    ev_fire = 1'b1;
                                    if ({1'b0, rem} < need) begin
                                        ev_code = EV_PAIR_ERR;
                                        pair_phase_next = PP_IGNORE;
                                    end else begin
                                        ev_code = EV_PAIR_LEN;
                                        ev_nlen = name_len_reg;
                                        ev_vlen = len_shift[15:0];
                                        pair_left_next = need;
                                        pair_phase_next = (need != 17'd0)
                                            ? PP_BYTES : PP_NAME_START;
                                    end
                                end
                            end
                        end
                        PP_BYTES: begin
                            ev_fire = 1'b1;
                            ev_byte = s_in_byte;
                            if (name_len_reg != 16'd0) begin
                                ev_code = EV_NAME;
                                name_len_next = name_len_reg - 16'd1;
                            end else begin
                                ev_code = EV_VALUE;
                            end
                            pair_left_next = pair_left_reg - 17'd1;
                            if (pair_left_reg == 17'd1) pair_phase_next = PP_NAME_START;
                        end
                        default: ;
                    endcase
                end
                if (last_byte) begin
                    phase_next = (pad_left_reg != 8'd0) ? PH_PADDING : PH_HEADER;
                end
            end
            PH_PADDING: begin
                pad_left_next = pad_left_reg - 8'd1;
                if (pad_left_reg == 8'd1) phase_next = PH_HEADER;
            end
            PH_DISCARD: begin
                if (s_chunk_last) phase_next = PH_HEADER;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            pair_phase_reg   <= PP_NAME_START;
            hdr_idx_reg      <= 3'd0;
            hdr_ver_reg      <= 8'd0;
            cur_type_reg     <= 8'd0;
            cur_req_reg      <= 16'd0;
            content_left_reg <= 16'd0;
            pad_left_reg     <= 8'd0;
            len_acc_reg      <= 32'd0;
            len_bytes_reg    <= 2'd0;
            name_len_reg     <= 16'd0;
            pair_left_reg    <= 17'd0;
            end_idx_reg      <= 3'd0;
            status_acc_reg   <= 32'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            // new event loads the output stage, else a drained one empties it
            if (accept && ev_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept) begin
                phase_reg        <= phase_next;
                pair_phase_reg   <= pair_phase_next;
                hdr_idx_reg      <= hdr_idx_next;
                hdr_ver_reg      <= hdr_ver_next;
                cur_type_reg     <= cur_type_next;
                cur_req_reg      <= cur_req_next;
                content_left_reg <= content_left_next;
                pad_left_reg     <= pad_left_next;
                len_acc_reg      <= len_acc_next;
                len_bytes_reg    <= len_bytes_next;
                name_len_reg     <= name_len_next;
                pair_left_reg    <= pair_left_next;
                end_idx_reg      <= end_idx_next;
                status_acc_reg   <= status_acc_next;
            end
        end
    end

    // payload of the output stage, loaded with each event
    always_ff @(posedge aclk) begin
        if (accept && ev_fire) begin
            ev_reg    <= ev_code;
            req_reg   <= cur_req_reg;
            obyte_reg <= ev_byte;
            nlen_reg  <= ev_nlen;
            vlen_reg  <= ev_vlen;
            app_reg   <= ev_app;
            proto_reg <= ev_proto;
            rtype_reg <= cur_type_reg;
            last_reg  <= (phase_reg == PH_CONTENT) && last_byte;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_res       = ev_reg;
    assign m_request_id      = req_reg;
    assign m_out_byte        = obyte_reg;
    assign m_name_length     = nlen_reg;
    assign m_value_length    = vlen_reg;
    assign m_app_status      = app_reg;
    assign m_protocol_status = proto_reg;
    assign m_record_type     = rtype_reg;
    assign m_last_of_record  = last_reg;

    // a waiting event is not overwritten
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(ev_reg))
        else $error("event dropped while stalled");

    // header index only moves in the header phase
    a_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER |=> $stable(hdr_idx_reg) || $past(accept))
        else $error("header index moved outside header");

    // pair byte counter is nonzero while pair bytes are tagged
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_phase_reg == PP_BYTES |-> pair_left_reg != 17'd0)
        else $error("pair byte counter empty");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// regression bench for the fastcgi record deframer: directed records for each
// record kind and error case, then random record streams, some with random idling,
// every event checked field by field against an in-bench parser model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import fcgi_pkg::*;

    // phases of the stream parser
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    // name-value pair decoding sub-states
    typedef enum logic [2:0] {
        PP_NAME_START  = 3'd0,
        PP_NAME_MORE   = 3'd1,
        PP_VALUE_START = 3'd2,
        PP_VALUE_MORE  = 3'd3,
        PP_BYTES       = 3'd4,
        PP_IGNORE      = 3'd6
    } pair_phase_t;

    typedef struct packed {
        logic [3:0]  ev;
        logic [15:0] req_id;
        logic [7:0]  data;
        logic [15:0] name_len;
        logic [15:0] value_len;
        logic [31:0] app_stat;
        logic [7:0]  proto_stat;
        logic [7:0]  rec_type;
        logic        last;
    } fcgi_event_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_REPORTS    = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_chunk_last;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_event_res;
    logic [15:0] m_request_id;
    logic [7:0]  m_out_byte;
    logic [15:0] m_name_length;
    logic [15:0] m_value_length;
    logic [31:0] m_app_status;
    logic [7:0]  m_protocol_status;
    logic [7:0]  m_record_type;
    logic        m_last_of_record;

    // parser model state
    phase_t      mdl_phase;
    logic [2:0]  mdl_hdr_idx;
    logic [7:0]  mdl_version;
    logic [7:0]  mdl_type;
    logic [15:0] mdl_req;
    logic [15:0] mdl_content_left;
    logic [7:0]  mdl_pad_left;
    pair_phase_t mdl_pair;
    logic [31:0] mdl_len_acc;
    logic [1:0]  mdl_len_left;
    logic [15:0] mdl_name_len;
    logic [16:0] mdl_pair_left;
    logic [2:0]  mdl_end_idx;
    logic [31:0] mdl_status_acc;

    fcgi_event_t expected_events[$];
    int          mismatch_count;
    int          event_count;
    int          byte_count;
    int          idle_cycles;
    bit          timed_out;
    bit          hold_sink;        // long receiver hold-off, set by the test sequence
    bit          sink_idle_on;     // random receiver stalls enabled
    int          src_gap_max;

    fastcgi_record_deframer i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_chunk_last      (s_chunk_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_res       (m_event_res),
        .m_request_id      (m_request_id),
        .m_out_byte        (m_out_byte),
        .m_name_length     (m_name_length),
        .m_value_length    (m_value_length),
        .m_app_status      (m_app_status),
        .m_protocol_status (m_protocol_status),
        .m_record_type     (m_record_type),
        .m_last_of_record  (m_last_of_record)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------

    // a pair error ends pair decoding for the rest of the record
    function automatic void pair_fail(ref fcgi_event_t e, ref bit hit);
        e.ev = EV_PAIR_ERR;
        hit = 1'b1;
        mdl_pair = PP_IGNORE;
    endfunction

    // name length known: a value length byte must still fit
    function automatic void name_done(logic [15:0] rem, ref fcgi_event_t e, ref bit hit);
        if (rem == 16'd0) begin
            pair_fail(e, hit);
        end else begin
            mdl_pair = PP_VALUE_START;
        end
    endfunction

    // both lengths known: name plus value must fit in the content left
    function automatic void value_done(logic [15:0] rem, ref fcgi_event_t e, ref bit hit);
        logic [32:0] need;
        need = {17'd0, mdl_name_len} + {1'b0, mdl_len_acc};
        if ({17'd0, rem} < need) begin
            pair_fail(e, hit);
        end else begin
            e.ev        = EV_PAIR_LEN;
            e.name_len  = mdl_name_len;
            e.value_len = mdl_len_acc[15:0];
            hit         = 1'b1;
            mdl_pair_left = need[16:0];
            mdl_pair = (need[16:0] != 17'd0) ? PP_BYTES : PP_NAME_START;
        end
    endfunction

    function automatic void decode_pair_byte(logic [7:0] b, logic [15:0] rem,
                                             ref fcgi_event_t e, ref bit hit);
        case (mdl_pair)
            PP_NAME_START, PP_VALUE_START: begin
                if ((b & LONG_LEN_FLAG) != 8'd0) begin
                    // four-byte length needs three more content bytes
                    if ({1'b0, rem} + 17'd1 < 17'd4) begin
                        pair_fail(e, hit);
                    end else begin
                        mdl_len_acc  = {24'd0, b & LEN_HIGH_MASK};
                        mdl_len_left = 2'd3;
                        mdl_pair = (mdl_pair == PP_NAME_START) ? PP_NAME_MORE : PP_VALUE_MORE;
                    end
                end else if (mdl_pair == PP_NAME_START) begin
                    mdl_name_len = {8'd0, b};
                    name_done(rem, e, hit);
                end else begin
                    mdl_len_acc = {24'd0, b};
                    value_done(rem, e, hit);
                end
            end
            PP_NAME_MORE, PP_VALUE_MORE: begin
                mdl_len_acc  = {mdl_len_acc[23:0], b};
                mdl_len_left = mdl_len_left - 2'd1;
                if (mdl_len_left == 2'd0) begin
                    if (mdl_len_acc > 32'h0000_ffff) begin
                        pair_fail(e, hit);
                    end else if (mdl_pair == PP_NAME_MORE) begin
                        mdl_name_len = mdl_len_acc[15:0];
                        name_done(rem, e, hit);
                    end else begin
                        value_done(rem, e, hit);
                    end
                end
            end
            PP_BYTES: begin
                e.data = b;
                if (mdl_name_len != 16'd0) begin
                    e.ev = EV_NAME;
                    mdl_name_len = mdl_name_len - 16'd1;
                end else begin
                    e.ev = EV_VALUE;
                end
                hit = 1'b1;
                mdl_pair_left = mdl_pair_left - 17'd1;
                if (mdl_pair_left == 17'd0) begin
                    mdl_pair = PP_NAME_START;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void reset_parser_model();
        mdl_phase = PH_HEADER;
        mdl_hdr_idx = '0;
        mdl_version = '0;
        mdl_type = '0;
        mdl_req = '0;
        mdl_content_left = '0;
        mdl_pad_left = '0;
        mdl_pair = PP_NAME_START;
        mdl_len_acc = '0;
        mdl_len_left = '0;
        mdl_name_len = '0;
        mdl_pair_left = '0;
        mdl_end_idx = '0;
        mdl_status_acc = '0;
    endfunction

    // advance the model by one accepted byte and queue the event it causes
    function automatic void predict_event(logic [7:0] b, logic cl);
        fcgi_event_t e;
        bit          hit;
        bit          last;
        e   = '0;
        hit = 1'b0;
        case (mdl_phase)
            PH_HEADER: begin
                case (mdl_hdr_idx)
                    3'd0: mdl_version = b;
                    3'd1: mdl_type = b;
                    3'd2: mdl_req[15:8] = b;
                    3'd3: mdl_req[7:0] = b;
                    3'd4: mdl_content_left[15:8] = b;
                    3'd5: mdl_content_left[7:0] = b;
                    3'd6: mdl_pad_left = b;
                    default: ;
                endcase
                if (mdl_hdr_idx != 3'd7) begin
                    mdl_hdr_idx = mdl_hdr_idx + 3'd1;
                end else begin
                    mdl_hdr_idx = 3'd0;
                    if (mdl_version != FCGI_VERSION || mdl_type == 8'd0 || mdl_type > TYPE_MAX) begin
                        e.ev = EV_BAD_HDR;
                        hit  = 1'b1;
                        mdl_phase = cl ? PH_HEADER : PH_DISCARD;
                    end else begin
                        mdl_end_idx = '0;
                        mdl_status_acc = '0;
                        mdl_len_acc = '0;
                        mdl_len_left = '0;
                        mdl_name_len = '0;
                        mdl_pair_left = '0;
                        mdl_pair = PP_NAME_START;
                        if (mdl_type == TYPE_END_REQUEST && mdl_content_left != 16'd8) begin
                            e.ev = EV_BAD_ENDLEN;
                            hit  = 1'b1;
                            mdl_pair = PP_IGNORE;
                        end else if (mdl_type != TYPE_END_REQUEST && mdl_type != TYPE_STDOUT &&
                                     mdl_type != TYPE_STDERR && mdl_type != TYPE_VALUES_RESULT) begin
                            e.ev = EV_UNEXP_TYPE;
                            hit  = 1'b1;
                            mdl_pair = PP_IGNORE;
                        end
                        if (mdl_content_left != 16'd0) begin
                            mdl_phase = PH_CONTENT;
                        end else begin
                            mdl_phase = (mdl_pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
                        end
                    end
                end
            end
            PH_CONTENT: begin
                mdl_content_left = mdl_content_left - 16'd1;
                last = (mdl_content_left == 16'd0);
                if (mdl_pair == PP_IGNORE) begin
                end else if (mdl_type == TYPE_STDOUT || mdl_type == TYPE_STDERR) begin
                    e.ev   = (mdl_type == TYPE_STDOUT) ? EV_STDOUT : EV_STDERR;
                    e.data = b;
                    hit    = 1'b1;
                end else if (mdl_type == TYPE_END_REQUEST) begin
                    // four status bytes, protocol status, three reserved
                    if (mdl_end_idx < 3'd4) begin
                        mdl_status_acc = {mdl_status_acc[23:0], b};
                    end else if (mdl_end_idx == 3'd4) begin
                        mdl_len_acc = {24'd0, b};
                    end
                    if (mdl_end_idx == 3'd7) begin
                        e.ev = EV_END_REQ;
                        e.app_stat = mdl_status_acc;
                        e.proto_stat = mdl_len_acc[7:0];
                        hit = 1'b1;
                    end
                    mdl_end_idx = mdl_end_idx + 3'd1;
                end else if (mdl_type == TYPE_VALUES_RESULT) begin
                    decode_pair_byte(b, mdl_content_left, e, hit);
                end
                e.last = last;
                if (last) begin
                    mdl_phase = (mdl_pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
                end
            end
            PH_PADDING: begin
                mdl_pad_left = mdl_pad_left - 8'd1;
                if (mdl_pad_left == 8'd0) begin
                    mdl_phase = PH_HEADER;
                end
            end
            default: begin
                if (cl) begin
                    mdl_phase = PH_HEADER;
                end
            end
        endcase
        if (hit) begin
            e.req_id   = mdl_req;
            e.rec_type = mdl_type;
            expected_events.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------------
    // byte source
    // ------------------------------------------------------------------------

    function automatic int random_gap(int max_gap);
        if (max_gap == 0 || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, max_gap);
    endfunction

    // offer one byte and hold it until accepted; valid drops only for a gap
    task automatic send_byte(input logic [7:0] b, input logic cl = 1'b0);
        int gap;
        gap = random_gap(src_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_byte    <= b;
        s_chunk_last <= cl;
        do begin
            @(posedge aclk);
        end while (!(s_ready === 1'b1));
        predict_event(b, cl);
        byte_count++;
    endtask

    task automatic send_header(input logic [7:0] ver, input logic [7:0] rtype,
                               input logic [15:0] rid, input logic [15:0] clen,
                               input logic [7:0] plen, input logic cl_last = 1'b0);
        send_byte(ver);
        send_byte(rtype);
        send_byte(rid[15:8]);
        send_byte(rid[7:0]);
        send_byte(clen[15:8]);
        send_byte(clen[7:0]);
        send_byte(plen);
        send_byte(8'($urandom_range(0, 255)), cl_last);
    endtask

    task automatic send_random_bytes(input int count);
        repeat (count) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic send_padding(input int plen);
        repeat (plen) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // data record: stdout or stderr
    task automatic send_data_record(input logic [7:0] rtype, input int clen, input int plen);
        send_header(FCGI_VERSION, rtype, 16'($urandom_range(0, 65535)), 16'(clen), 8'(plen));
        send_random_bytes(clen);
        send_padding(plen);
    endtask

    task automatic send_end_record(input logic [15:0] rid, input logic [31:0] app,
                                   input logic [7:0] proto, input int plen);
        send_header(FCGI_VERSION, TYPE_END_REQUEST, rid, 16'd8, 8'(plen));
        send_byte(app[31:24]);
        send_byte(app[23:16]);
        send_byte(app[15:8]);
        send_byte(app[7:0]);
        send_byte(proto);
        send_random_bytes(3);
        send_padding(plen);
    endtask

    // pair length encoding: short form below 128 unless forced long, else 4-byte form
    function automatic int length_size(int len, bit force_long);
        return (len > 127 || force_long) ? 4 : 1;
    endfunction

    task automatic send_length(input logic [31:0] len, input bit force_long);
        if (len > 127 || force_long) begin
            send_byte(LONG_LEN_FLAG | {1'b0, len[30:24]});
            send_byte(len[23:16]);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else begin
            send_byte(len[7:0]);
        end
    endtask

    // get-values-result record with well-formed pairs
    task automatic send_pairs_record(input int npairs, input int plen, input int maxlen);
        int nl[8];
        int vl[8];
        bit nlong[8];
        bit vlong[8];
        int total;
        total = 0;
        for (int k = 0; k < npairs; k++) begin
            nl[k] = $urandom_range(0, maxlen);
            vl[k] = $urandom_range(0, maxlen);
            nlong[k] = ($urandom_range(0, 4) == 0);
            vlong[k] = ($urandom_range(0, 4) == 0);
            total += length_size(nl[k], nlong[k]) + length_size(vl[k], vlong[k]) + nl[k] + vl[k];
        end
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'($urandom_range(0, 65535)),
                    16'(total), 8'(plen));
        for (int k = 0; k < npairs; k++) begin
            send_length(nl[k], nlong[k]);
            send_length(vl[k], vlong[k]);
            send_random_bytes(nl[k] + vl[k]);
        end
        send_padding(plen);
    endtask

    // wait until every expected event has drained and the block is quiet
    task automatic drain_events();
        s_valid <= 1'b0;
        while (expected_events.size() != 0 && !timed_out) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_data_records();
        send_data_record(TYPE_STDOUT, 3, 0);
        send_data_record(TYPE_STDERR, 2, 2);
        send_header(FCGI_VERSION, TYPE_STDOUT, 16'hffff, 16'd0, 8'd0);    // empty content
        send_header(FCGI_VERSION, TYPE_STDERR, 16'h0000, 16'd0, 8'd3);    // padding only
        send_padding(3);
        send_byte(8'hff);
        send_byte(8'h00);
    endtask

    task automatic test_headers_and_errors();
        // fill the partially sent header above, then more errors
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);                                           // type 0: bad header
        send_random_bytes(2);
        send_byte(8'h55, 1'b1);                                     // ends discard
        send_header(8'h02, TYPE_STDOUT, 16'h1234, 16'd1, 8'd0, 1'b1); // bad version, chunk end
        send_header(FCGI_VERSION, 8'd12, 16'h0001, 16'd0, 8'd0);    // type above range
        send_byte(8'hab, 1'b1);
        send_header(8'hff, 8'hff, 16'hffff, 16'hffff, 8'hff);        // all ones, bad
        send_byte(8'h00, 1'b1);
        send_header(FCGI_VERSION, TYPE_END_REQUEST, 16'h0042, 16'd3, 8'd1); // bad end length
        send_random_bytes(4);
        send_header(FCGI_VERSION, 8'd1, 16'h0007, 16'd2, 8'd0);     // unexpected type
        send_random_bytes(2);
        send_header(FCGI_VERSION, TYPE_MAX, 16'h0008, 16'd0, 8'd0);
    endtask

    task automatic test_end_request();
        send_end_record(16'hffff, 32'hffff_ffff, 8'hff, 0);
        send_end_record(16'h0000, 32'h0000_0000, 8'h00, 1);
        send_end_record(16'h8001, 32'h8000_0001, 8'h80, 0);
    endtask

    task automatic test_pairs_directed();
        send_pairs_record(2, 0, 3);
        // 4-byte length 65535 name with no room: overrun error
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0100, 16'd6, 8'd0);
        send_length(32'h0000_ffff, 1'b1);
        send_byte(8'h00);
        send_byte(8'h11);
        // length above 65535
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0101, 16'd5, 8'd0);
        send_length(32'h7fff_ffff, 1'b1);
        send_byte(8'h22);
        // long length flag with too few bytes left
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0102, 16'd2, 8'd0);
        send_byte(8'h80);
        send_byte(8'h01);
        // name length on the last byte: no room for the value length
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0103, 16'd1, 8'd0);
        send_byte(8'h00);
        // zero-length pair
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0104, 16'd2, 8'd0);
        send_byte(8'h00);
        send_byte(8'h00);
        // long name 200 bytes
        send_pairs_record(1, 0, 0);
        send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'h0105, 16'd205, 8'd0);
        send_length(32'd200, 1'b0);
        send_byte(8'd0);
        send_random_bytes(200);
    endtask

    // random stream: mostly well-formed records with random content
    task automatic test_random_stream(input int nbytes);
        int start;
        int pick;
        start = byte_count;
        while (byte_count - start < nbytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_data_record($urandom_range(0, 1) ? TYPE_STDOUT : TYPE_STDERR,
                                 $urandom_range(0, 12), $urandom_range(0, 3));
            end else if (pick < 55) begin
                send_pairs_record($urandom_range(1, 3), $urandom_range(0, 2), 6);
            end else if (pick < 70) begin
                send_end_record(16'($urandom_range(0, 65535)), $urandom(),
                                8'($urandom_range(0, 255)), $urandom_range(0, 2));
            end else if (pick < 80) begin
                // arbitrary header with valid version: error paths and random lengths
                send_header(FCGI_VERSION, 8'($urandom_range(0, 13)),
                            16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 10)), 8'($urandom_range(0, 2)));
                send_random_bytes($urandom_range(0, 12));
            end else if (pick < 90) begin
                // get-values-result with random content: broken pairs
                send_header(FCGI_VERSION, TYPE_VALUES_RESULT, 16'($urandom_range(0, 65535)),
                            16'($urandom_range(0, 12)), 8'd0);
                send_random_bytes($urandom_range(0, 14));
            end else begin
                send_random_bytes($urandom_range(1, 20));
            end
        end
        // send a byte flagged as a chunk end, which ends any discard in progress
        send_byte(8'h00, 1'b1);
    endtask

    // receiver holds off while the source keeps offering stdout bytes
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            send_data_record(TYPE_STDOUT, 40, 0);
            begin
                int held;
                held = 0;
                while (held < 200) begin
                    @(posedge aclk);
                    held++;
                end
                hold_sink = 1'b0;
            end
        join
    endtask

    // ------------------------------------------------------------------------
    // result checker and receiver
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_sink) begin
            m_ready <= 1'b0;
        end else if (sink_idle_on) begin
            m_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 30) == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        fcgi_event_t got;
        fcgi_event_t exp_ev;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            got = '{m_event_res, m_request_id, m_out_byte, m_name_length, m_value_length,
                    m_app_status, m_protocol_status, m_record_type, m_last_of_record};
            event_count++;
            if (expected_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected event %0d at %0t", got.ev, $realtime);
                end
            end else begin
                exp_ev = expected_events.pop_front();
                if (got !== exp_ev) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("event mismatch at %0t", $realtime);
                        $display("  expected ev=%0d id=%h byte=%h nl=%h vl=%h app=%h ps=%h type=%h last=%b",
                                 exp_ev.ev, exp_ev.req_id, exp_ev.data, exp_ev.name_len,
                                 exp_ev.value_len, exp_ev.app_stat, exp_ev.proto_stat,
                                 exp_ev.rec_type, exp_ev.last);
                        $display("  actual   ev=%0d id=%h byte=%h nl=%h vl=%h app=%h ps=%h type=%h last=%b",
                                 got.ev, got.req_id, got.data, got.name_len, got.value_len,
                                 got.app_stat, got.proto_stat, got.rec_type, got.last);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no request and no event moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
                $display("fastcgi_record_deframer regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'd0;
        s_chunk_last = 1'b0;
        m_ready = 1'b0;
        mismatch_count = 0;
        event_count = 0;
        byte_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        hold_sink = 1'b0;
        sink_idle_on = 1'b0;
        src_gap_max = 0;
        reset_parser_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_data_records();
        test_headers_and_errors();
        test_end_request();
        test_pairs_directed();
        drain_events();

        test_random_stream(200);              // full rate, no stalls
        sink_idle_on = 1'b1;
        src_gap_max = 3;
        test_random_stream(400);              // random idling on both sides
        test_backpressure();
        src_gap_max = 0;
        test_random_stream(200);              // full-rate source, stalling sink
        sink_idle_on = 1'b0;
        drain_events();
        repeat (10) @(posedge aclk);

        $display("covered %0d stream bytes and %0d events: data, pair, end request", byte_count,
                 event_count);
        $display("records, header and pair errors, discard, and long sink hold-off");
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("fastcgi_record_deframer regression: pass");
        end else begin
            $display("%0d mismatches, %0d events missing", mismatch_count, expected_events.size());
            $display("fastcgi_record_deframer regression: fail");
        end
        $finish;
    end

endmodule

// ===== fastcgi_record_deframer.f =====
sv/fcgi_pkg.sv
sv/fastcgi_record_deframer.sv
bench/tb.sv
